/* design/perspective_warp_bilinear_assert.svh */
// ----------------------------------------------------------------------------
// perspective warp assertion macros
// shared concurrent assertion forms for the warp block
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH
`define PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH

// same-cycle implication
`define PWB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PWB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pwb_pkg.sv */
// ----------------------------------------------------------------------------
// pwb_pkg
// shared types and constants of the perspective warp block
// ----------------------------------------------------------------------------
`default_nettype none

package pwb_pkg;

   localparam int COEF_W    = 48;
   localparam int NUM_COEF  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int POS_W     = 12;
   localparam int CHAN_W    = 8;
   localparam int FRAC_W    = 8;
   localparam int QUOT_W    = POS_W + FRAC_W;
   // numerators and denominator are exact signed sums
   localparam int NUM_W     = 62;
   localparam int DIV_R_W   = NUM_W + QUOT_W;
   localparam int DIV_D_W   = NUM_W - 1;
   localparam int CHAN_MAX  = 255;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam int DEF_SRC_WIDTH  = 512;
   localparam int DEF_SRC_HEIGHT = 512;
   localparam int QUEUE_DEPTH    = 4;
   localparam int OUT_DEPTH      = 32;

   localparam logic signed [NUM_W-1:0] Q_ONE = 62'sd4294967296;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_A = 3'd0,
      CSR_COEF_B = 3'd1,
      CSR_COEF_C = 3'd2,
      CSR_COEF_D = 3'd3,
      CSR_COEF_E = 3'd4,
      CSR_COEF_F = 3'd5,
      CSR_COEF_G = 3'd6,
      CSR_COEF_H = 3'd7
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_WARP = 1'b1
   } op_type;

   localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
      48'sd4294967296, 48'sd0, 48'sd0,
      48'sd0, 48'sd4294967296, 48'sd0,
      48'sd0, 48'sd0
   };

   // classified word handed from front to back
   typedef struct packed {
      op_type             op;
      logic               ld_ok;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } item_type;

   typedef struct packed {
      logic               in_frame;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  red;
   } pixel_type;

endpackage

`default_nettype wire

/* design/pwb_ram.sv */
// ----------------------------------------------------------------------------
// pwb_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/pwb_fifo.sv */
// ----------------------------------------------------------------------------
// pwb_fifo
// small register fifo with first-word fall-through
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = mem_ff[rd_ptr_ff];
   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);

endmodule

`default_nettype wire

/* design/pwb_front.sv */
// ----------------------------------------------------------------------------
// pwb_front
// accepts request words, unpacks and classifies them for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_front #(
   parameter int SRC_WIDTH  = pwb_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = pwb_pkg::DEF_SRC_HEIGHT
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pwb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            q_full,
   output logic                            q_push,
   output pwb_pkg::item_type               q_item
);

   localparam int POS_W = pwb_pkg::POS_W;

   // take a word whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // unpack and flag loads that land inside the frame
   always_comb begin
      q_item.op    = pwb_pkg::op_type'(req_tuser);
      q_item.pos_x = req_tdata[POS_W-1:0];
      q_item.pos_y = req_tdata[2*POS_W-1:POS_W];
      q_item.red   = req_tdata[31:24];
      q_item.green = req_tdata[39:32];
      q_item.blue  = req_tdata[47:40];
      q_item.ld_ok = ({1'b0, q_item.pos_x} < (POS_W + 1)'(SRC_WIDTH)) &&
                     ({1'b0, q_item.pos_y} < (POS_W + 1)'(SRC_HEIGHT));
   end

endmodule

`default_nettype wire

/* design/pwb_div.sv */
// ----------------------------------------------------------------------------
// pwb_div
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_div #(
   parameter int PAY_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic                          in_ok,
   input  logic [pwb_pkg::DIV_R_W-1:0]   in_rx,
   input  logic [pwb_pkg::DIV_R_W-1:0]   in_ry,
   input  logic [pwb_pkg::DIV_D_W-1:0]   in_d,
   input  logic [PAY_W-1:0]              in_pay,
   output logic                          out_vld,
   output logic                          out_ok,
   output logic [pwb_pkg::QUOT_W-1:0]    out_qx,
   output logic [pwb_pkg::QUOT_W-1:0]    out_qy,
   output logic [PAY_W-1:0]              out_pay
);

   localparam int QW  = pwb_pkg::QUOT_W;
   localparam int R_W = pwb_pkg::DIV_R_W;
   localparam int D_W = pwb_pkg::DIV_D_W;

   logic            vld_ff [QW];
   logic            ok_ff  [QW];
   logic [R_W-1:0]  rx_ff  [QW];
   logic [R_W-1:0]  ry_ff  [QW];
   logic [D_W-1:0]  d_ff   [QW];
   logic [QW-1:0]   qx_ff  [QW];
   logic [QW-1:0]   qy_ff  [QW];
   logic [PAY_W-1:0] pay_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int BIT = QW - 1 - s;

      logic            vld_prev, ok_prev;
      logic [R_W-1:0]  rx_prev, ry_prev, dsh, rx_in, ry_in;
      logic [D_W-1:0]  d_prev;
      logic [QW-1:0]   qx_prev, qy_prev, qx_in, qy_in;
      logic [PAY_W-1:0] pay_prev;

      if (s == 0) begin : g_head
         assign vld_prev = in_vld;
         assign ok_prev  = in_ok;
         assign rx_prev  = in_rx;
         assign ry_prev  = in_ry;
         assign d_prev   = in_d;
         assign qx_prev  = '0;
         assign qy_prev  = '0;
         assign pay_prev = in_pay;
      end else begin : g_body
         assign vld_prev = vld_ff[s-1];
         assign ok_prev  = ok_ff[s-1];
         assign rx_prev  = rx_ff[s-1];
         assign ry_prev  = ry_ff[s-1];
         assign d_prev   = d_ff[s-1];
         assign qx_prev  = qx_ff[s-1];
         assign qy_prev  = qy_ff[s-1];
         assign pay_prev = pay_ff[s-1];
      end

      // compare against the shifted divisor and subtract
      always_comb begin
         dsh   = R_W'(d_prev) << BIT;
         rx_in = rx_prev;
         ry_in = ry_prev;
         qx_in = qx_prev;
         qy_in = qy_prev;
         if (rx_prev >= dsh) begin
            rx_in = rx_prev - dsh;
            qx_in[BIT] = 1'b1;
         end
         if (ry_prev >= dsh) begin
            ry_in = ry_prev - dsh;
            qy_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         ok_ff[s]  <= ok_prev;
         rx_ff[s]  <= rx_in;
         ry_ff[s]  <= ry_in;
         d_ff[s]   <= d_prev;
         qx_ff[s]  <= qx_in;
         qy_ff[s]  <= qy_in;
         pay_ff[s] <= pay_prev;
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_ok  = ok_ff[QW-1];
   assign out_qx  = qx_ff[QW-1];
   assign out_qy  = qy_ff[QW-1];
   assign out_pay = pay_ff[QW-1];

endmodule

`default_nettype wire

/* design/pwb_back.sv */
// ----------------------------------------------------------------------------
// pwb_back
// coefficient registers, mapping pipeline, banked frame memory and blend
// ----------------------------------------------------------------------------
`default_nettype none

`include "perspective_warp_bilinear_assert.svh"

module pwb_back #(
   parameter int SRC_WIDTH  = pwb_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = pwb_pkg::DEF_SRC_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pwb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwb_pkg::COEF_W-1:0]      csr_wdata,
   input  logic                            q_empty,
   input  pwb_pkg::item_type               q_item,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pwb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int COEF_W     = pwb_pkg::COEF_W;
   localparam int POS_W      = pwb_pkg::POS_W;
   localparam int NUM_W      = pwb_pkg::NUM_W;
   localparam int FRAC_W     = pwb_pkg::FRAC_W;
   localparam int CHAN_W     = pwb_pkg::CHAN_W;
   localparam int PROD_W     = COEF_W + POS_W + 1;
   localparam int HALF_W     = (SRC_WIDTH + 1) / 2;
   localparam int HALF_H     = (SRC_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int WADDR_W    = 2 * POS_W + 1;
   localparam int PEND_W     = $clog2(pwb_pkg::OUT_DEPTH + 1);
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int WGT_W      = 2 * FRAC_W + 1;
   localparam int ACC_W      = WGT_W + CHAN_W;
   localparam int PAY_W      = $bits(pwb_pkg::item_type);

   // coefficient registers
   logic signed [COEF_W-1:0] coef_ff [pwb_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwb_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= pwb_pkg::COEF_RESET[i];
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // output credit: warps popped and not yet taken
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic pop_warp, rsp_acc;

   assign q_pop    = !q_empty && (pend_ff < PEND_W'(pwb_pkg::OUT_DEPTH));
   assign pop_warp = q_pop && (q_item.op == pwb_pkg::OP_WARP);
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign pend_in  = pend_ff + PEND_W'(pop_warp) - PEND_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // stage 1: coefficient products
   logic                      s1_vld_ff;
   pwb_pkg::item_type         s1_item_ff;
   logic signed [PROD_W-1:0]  s1_ax_ff, s1_by_ff, s1_dx_ff, s1_ey_ff, s1_gx_ff, s1_hy_ff;
   logic signed [POS_W:0]     x_s, y_s;

   assign x_s = signed'({1'b0, q_item.pos_x});
   assign y_s = signed'({1'b0, q_item.pos_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= q_item;
      s1_ax_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_A]) * PROD_W'(x_s);
      s1_by_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_B]) * PROD_W'(y_s);
      s1_dx_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_D]) * PROD_W'(x_s);
      s1_ey_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_E]) * PROD_W'(y_s);
      s1_gx_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_G]) * PROD_W'(x_s);
      s1_hy_ff   <= PROD_W'(coef_ff[pwb_pkg::CSR_COEF_H]) * PROD_W'(y_s);
   end

   // stage 2: numerators and denominator
   logic                     s2_vld_ff;
   pwb_pkg::item_type        s2_item_ff;
   logic signed [NUM_W-1:0]  s2_nx_ff, s2_ny_ff, s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_item_ff <= s1_item_ff;
      s2_nx_ff   <= NUM_W'(s1_ax_ff) + NUM_W'(s1_by_ff) +
                    NUM_W'(coef_ff[pwb_pkg::CSR_COEF_C]);
      s2_ny_ff   <= NUM_W'(s1_dx_ff) + NUM_W'(s1_ey_ff) +
                    NUM_W'(coef_ff[pwb_pkg::CSR_COEF_F]);
      s2_den_ff  <= NUM_W'(s1_gx_ff) + NUM_W'(s1_hy_ff) + pwb_pkg::Q_ONE;
   end

   // stage 3: sign checks and quotient below 4096
   logic                               s3_vld_ff, s3_ok_ff;
   pwb_pkg::item_type                  s3_item_ff;
   logic [pwb_pkg::DIV_R_W-1:0]        s3_rx_ff, s3_ry_ff;
   logic [pwb_pkg::DIV_D_W-1:0]        s3_d_ff;
   logic                               den_pos, nx_ok, ny_ok;

   always_comb begin
      den_pos = !s2_den_ff[NUM_W-1] && (s2_den_ff != '0);
      nx_ok   = !s2_nx_ff[NUM_W-1] &&
                ({{POS_W{1'b0}}, s2_nx_ff} < {s2_den_ff, {POS_W{1'b0}}});
      ny_ok   = !s2_ny_ff[NUM_W-1] &&
                ({{POS_W{1'b0}}, s2_ny_ff} < {s2_den_ff, {POS_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_item_ff <= s2_item_ff;
      s3_ok_ff   <= den_pos && nx_ok && ny_ok;
      s3_rx_ff   <= pwb_pkg::DIV_R_W'({s2_nx_ff[NUM_W-2:0], {FRAC_W{1'b0}}});
      s3_ry_ff   <= pwb_pkg::DIV_R_W'({s2_ny_ff[NUM_W-2:0], {FRAC_W{1'b0}}});
      s3_d_ff    <= s2_den_ff[NUM_W-2:0];
   end

   // divider pipeline
   logic                        dv_vld, dv_ok;
   logic [pwb_pkg::QUOT_W-1:0]  dv_qx, dv_qy;
   logic [PAY_W-1:0]            dv_pay;
   pwb_pkg::item_type           dv_item;

   pwb_div #(
      .PAY_W (PAY_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s3_vld_ff),
      .in_ok   (s3_ok_ff),
      .in_rx   (s3_rx_ff),
      .in_ry   (s3_ry_ff),
      .in_d    (s3_d_ff),
      .in_pay  (s3_item_ff),
      .out_vld (dv_vld),
      .out_ok  (dv_ok),
      .out_qx  (dv_qx),
      .out_qy  (dv_qy),
      .out_pay (dv_pay)
   );

   assign dv_item = pwb_pkg::item_type'(dv_pay);

   // frame position: loads use their own, warps the mapped integer part
   logic [POS_W-1:0] sel_x, sel_y;
   logic             range_ok;

   always_comb begin
      if (dv_item.op == pwb_pkg::OP_WARP) begin
         sel_x = dv_qx[pwb_pkg::QUOT_W-1:FRAC_W];
         sel_y = dv_qy[pwb_pkg::QUOT_W-1:FRAC_W];
      end else begin
         sel_x = dv_item.pos_x;
         sel_y = dv_item.pos_y;
      end
      range_ok = ({1'b0, sel_x} < (POS_W + 1)'(SRC_WIDTH - 1)) &&
                 ({1'b0, sel_y} < (POS_W + 1)'(SRC_HEIGHT - 1));
   end

   // four banks by column and row parity, one neighbor in each
   logic [PIX_W-1:0] bank_rdata [4];

   for (genvar p = 0; p < 4; p++) begin : g_bank
      localparam logic [1:0] PB = 2'(p);

      logic [POS_W:0]    xb, yb;
      logic [ADDR_W-1:0] addr;
      logic              we;

      always_comb begin
         xb   = {1'b0, sel_x} + (POS_W + 1)'(sel_x[0] != PB[0]);
         yb   = {1'b0, sel_y} + (POS_W + 1)'(sel_y[0] != PB[1]);
         addr = ADDR_W'(WADDR_W'(yb[POS_W:1]) * WADDR_W'(HALF_W) + WADDR_W'(xb[POS_W:1]));
         we   = dv_vld && (dv_item.op == pwb_pkg::OP_LOAD) && dv_item.ld_ok &&
                ({dv_item.pos_y[0], dv_item.pos_x[0]} == PB);
      end

      pwb_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (we),
         .waddr (addr),
         .wdata ({dv_item.red, dv_item.green, dv_item.blue}),
         .raddr (addr),
         .rdata (bank_rdata[p])
      );
   end

   // stage a: memory read in flight
   logic              sa_vld_ff, sa_ok_ff, sa_x0_ff, sa_y0_ff;
   logic [FRAC_W-1:0] sa_u_ff, sa_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= dv_vld && (dv_item.op == pwb_pkg::OP_WARP);
      end
   end

   always_ff @(posedge clock) begin
      sa_ok_ff <= dv_ok && range_ok;
      sa_x0_ff <= sel_x[0];
      sa_y0_ff <= sel_y[0];
      sa_u_ff  <= dv_qx[FRAC_W-1:0];
      sa_v_ff  <= dv_qy[FRAC_W-1:0];
   end

   // stage b: weights and neighbor steering
   logic              sb_vld_ff, sb_ok_ff;
   logic [WGT_W-1:0]  sb_w00_ff, sb_w01_ff, sb_w10_ff, sb_w11_ff;
   logic [PIX_W-1:0]  sb_p00_ff, sb_p01_ff, sb_p10_ff, sb_p11_ff;
   logic [FRAC_W:0]   inv_u, inv_v;

   assign inv_u = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(sa_u_ff);
   assign inv_v = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(sa_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_vld_ff <= 1'b0;
      end else begin
         sb_vld_ff <= sa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sb_ok_ff  <= sa_ok_ff;
      sb_w00_ff <= WGT_W'(inv_u) * WGT_W'(inv_v);
      sb_w01_ff <= WGT_W'(inv_u) * WGT_W'(sa_v_ff);
      sb_w10_ff <= WGT_W'(sa_u_ff) * WGT_W'(inv_v);
      sb_w11_ff <= WGT_W'(sa_u_ff) * WGT_W'(sa_v_ff);
      sb_p00_ff <= bank_rdata[{sa_y0_ff, sa_x0_ff}];
      sb_p01_ff <= bank_rdata[{!sa_y0_ff, sa_x0_ff}];
      sb_p10_ff <= bank_rdata[{sa_y0_ff, !sa_x0_ff}];
      sb_p11_ff <= bank_rdata[{!sa_y0_ff, !sa_x0_ff}];
   end

   // stage c: weighted sums, clamp, into the output fifo
   logic [CHAN_W-1:0] chan [3];
   logic [ACC_W-1:0]  acc  [3];
   logic [ACC_W-2*FRAC_W-1:0] shr [3];
   pwb_pkg::pixel_type out_pix, out_head;
   logic out_push, out_full, out_empty;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = ACC_W'(sb_p00_ff[c*CHAN_W +: CHAN_W]) * ACC_W'(sb_w00_ff) +
                  ACC_W'(sb_p01_ff[c*CHAN_W +: CHAN_W]) * ACC_W'(sb_w01_ff) +
                  ACC_W'(sb_p10_ff[c*CHAN_W +: CHAN_W]) * ACC_W'(sb_w10_ff) +
                  ACC_W'(sb_p11_ff[c*CHAN_W +: CHAN_W]) * ACC_W'(sb_w11_ff);
         shr[c] = acc[c][ACC_W-1:2*FRAC_W];
         if (!sb_ok_ff) begin
            chan[c] = '0;
         end else if (shr[c] > (ACC_W - 2*FRAC_W)'(pwb_pkg::CHAN_MAX)) begin
            chan[c] = CHAN_W'(pwb_pkg::CHAN_MAX);
         end else begin
            chan[c] = shr[c][CHAN_W-1:0];
         end
      end
      out_pix.in_frame = sb_ok_ff;
      out_pix.blue     = chan[0];
      out_pix.green    = chan[1];
      out_pix.red      = chan[2];
   end

   assign out_push = sb_vld_ff;

   pwb_fifo #(
      .WIDTH ($bits(pwb_pkg::pixel_type)),
      .DEPTH (pwb_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_pix),
      .pop   (rsp_acc),
      .dout  (out_head),
      .full  (out_full),
      .empty (out_empty)
   );

   assign rsp_tvalid = !out_empty;
   assign rsp_tdata  = {out_head.blue, out_head.green, out_head.red};
   assign rsp_tuser  = out_head.in_frame;

   // checks
   `PWB_ASSERT_IMPL(a_out_no_overflow, clock, reset, out_push, !out_full,
      "result pushed into full output fifo")
   `PWB_ASSERT_IMPL(a_pend_bound, clock, reset, 1'b1,
      pend_ff <= PEND_W'(pwb_pkg::OUT_DEPTH), "pending count above fifo depth")
   `PWB_ASSERT_IMPL(a_rsp_pending, clock, reset, rsp_tvalid, pend_ff != '0,
      "result shown with nothing pending")
   `PWB_ASSERT_IMPL(a_outside_black, clock, reset, out_push && !out_pix.in_frame,
      (out_pix.red == '0) && (out_pix.green == '0) && (out_pix.blue == '0),
      "outside result carries color")
   `PWB_ASSERT_NEXT(a_pop_counts, clock, reset, pop_warp && !rsp_acc,
      pend_ff != '0, "popped warp not counted")

endmodule

`default_nettype wire

/* design/perspective_warp_bilinear.sv */
// ----------------------------------------------------------------------------
// perspective_warp_bilinear
// homography inverse warp with bilinear sampling of a stored rgb frame
// ----------------------------------------------------------------------------
// The block takes one word per clock while the queue has room, loads and
// warps alike, and returns one result per warp at one per clock while
// rsp_tready stays high. A warp result passes through the 20-stage pipelined
// divider (12 integer and 8 fraction bits per coordinate), with product, sum,
// check, memory and blend stages around it. The frame sits in four banks
// split by column and row parity, so the four neighbors are read in the same
// cycle; loads write in pipeline order, so a warp sees every load taken before
// it. Frame entries hold nothing meaningful until loaded and there is no
// clearing pass. A 4-word queue parts intake from the pipeline and a 32-word
// output fifo absorbs results while the consumer stalls.
`default_nettype none

module perspective_warp_bilinear #(
   parameter int SRC_WIDTH  = pwb_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = pwb_pkg::DEF_SRC_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = pos_x, pos_y, in_red, in_green, in_blue; tuser = op
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pwb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   // result: tdata = out_red, out_green, out_blue; tuser = inside_res
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pwb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   // coefficient writes
   input  logic                            csr_we,
   input  logic [pwb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwb_pkg::COEF_W-1:0]      csr_wdata
);

   pwb_pkg::item_type fr_item, q_head;
   logic fr_push, q_full, q_empty, q_pop;

   pwb_front #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (fr_push),
      .q_item     (fr_item)
   );

   pwb_fifo #(
      .WIDTH ($bits(pwb_pkg::item_type)),
      .DEPTH (pwb_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fr_push),
      .din   (fr_item),
      .pop   (q_pop),
      .dout  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   pwb_back #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_empty    (q_empty),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* tb/tb_perspective_warp_bilinear.sv */
// ----------------------------------------------------------------------------
// tb_perspective_warp_bilinear
// self-checking bench for the homography warp with bilinear rgb sampling
// ----------------------------------------------------------------------------
// Loads and warps are sent on the request stream and every warp result is
// compared with a local model of the coefficients and the source frame. Any
// warp that samples unloaded neighbors gets those neighbors loaded first.
// Coefficients change only while the block is idle, across identity, scaled,
// degenerate, extreme and random perspective settings, with random gaps on
// both streams and a long consumer hold-off that backs up the pipeline.
`default_nettype none

module tb_perspective_warp_bilinear;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_W    = pwb_pkg::DEF_SRC_WIDTH;
   localparam int FRAME_H    = pwb_pkg::DEF_SRC_HEIGHT;
   localparam int POS_W      = pwb_pkg::POS_W;
   localparam int CHAN_W     = pwb_pkg::CHAN_W;
   localparam int NUM_COEF   = pwb_pkg::NUM_COEF;
   localparam int COEF_W     = pwb_pkg::COEF_W;
   localparam int CHAN_MAX   = pwb_pkg::CHAN_MAX;
   localparam int REQ_DATA_W = pwb_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = pwb_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W  = pwb_pkg::CSR_IDX_W;
   localparam longint ONE_Q = 64'sd4294967296;
   localparam longint COEF_MAX = 64'sd140737488355327;
   localparam longint COEF_MIN = -64'sd140737488355328;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              in_frame;
   } warp_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COEF_W-1:0]     csr_wdata = '0;

   // model state
   longint         coef [NUM_COEF];
   bit [23:0]      frame_rgb [FRAME_W*FRAME_H];
   bit             frame_loaded [FRAME_W*FRAME_H];
   warp_pixel_type pending_pixels [$];

   int  errors = 0;
   int  n_loads = 0;
   int  n_warps = 0;
   int  n_inside = 0;
   int  n_checked = 0;
   int  hold_cycles = 0;
   bit  quiet_streams = 0;

   perspective_warp_bilinear i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // integer part and 8-bit truncated fraction of num/den
   function automatic bit split_quotient(input longint num, input longint den,
                                         input int limit, output int ip, output int fp);
      logic [63:0] n, d, q, r;
      int f;
      n = num;
      d = den;
      q = n / d;
      r = n % d;
      f = 0;
      ip = 0;
      fp = 0;
      if (q >= limit) return 0;
      for (int i = 0; i < 8; i++) begin
         r = r << 1;
         f = f << 1;
         if (r >= d) begin
            r = r - d;
            f = f | 1;
         end
      end
      ip = int'(q);
      fp = f;
      return 1;
   endfunction

   // maps an output pixel into the source, reports the top-left neighbor
   function automatic bit map_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                    output int lx, output int ly, output int u, output int v);
      longint x, y, nx, ny, den;
      bit ok;
      x = longint'(px);
      y = longint'(py);
      nx = coef[0] * x + coef[1] * y + coef[2];
      ny = coef[3] * x + coef[4] * y + coef[5];
      den = coef[6] * x + coef[7] * y + ONE_Q;
      lx = 0;
      ly = 0;
      u = 0;
      v = 0;
      ok = den > 0 && nx >= 0 && ny >= 0;
      if (ok) ok = split_quotient(nx, den, FRAME_W - 1, lx, u);
      if (ok) ok = split_quotient(ny, den, FRAME_H - 1, ly, v);
      return ok;
   endfunction

   // bilinear blend of the four neighbors
   function automatic warp_pixel_type blend_pixel(input logic [POS_W-1:0] px,
                                                  input logic [POS_W-1:0] py);
      warp_pixel_type res;
      int lx, ly, u, v, sh;
      int unsigned w00, w01, w10, w11, acc;
      int unsigned chan [3];
      res = '{default: '0};
      if (!map_point(px, py, lx, ly, u, v)) return res;
      w00 = (256 - u) * (256 - v);
      w01 = (256 - u) * v;
      w10 = u * (256 - v);
      w11 = u * v;
      for (int c = 0; c < 3; c++) begin
         sh = 16 - 8 * c;
         acc = ((frame_rgb[ly * FRAME_W + lx] >> sh) & 8'hff) * w00
             + ((frame_rgb[(ly + 1) * FRAME_W + lx] >> sh) & 8'hff) * w01
             + ((frame_rgb[ly * FRAME_W + lx + 1] >> sh) & 8'hff) * w10
             + ((frame_rgb[(ly + 1) * FRAME_W + lx + 1] >> sh) & 8'hff) * w11;
         acc = acc >> 16;
         if (acc > CHAN_MAX) acc = CHAN_MAX;
         chan[c] = acc;
      end
      res.red = CHAN_W'(chan[0]);
      res.green = CHAN_W'(chan[1]);
      res.blue = CHAN_W'(chan[2]);
      res.in_frame = 1'b1;
      return res;
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // sends one word and records what it should cause
   task automatic send_word(input pwb_pkg::op_type op, input logic [POS_W-1:0] px,
                            input logic [POS_W-1:0] py, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, g, r, py, px};
      do @(posedge clock); while (!req_tready);
      if (op == pwb_pkg::OP_LOAD) begin
         n_loads++;
         if (px < FRAME_W && py < FRAME_H) begin
            frame_rgb[py * FRAME_W + px] = {r, g, b};
            frame_loaded[py * FRAME_W + px] = 1'b1;
         end
      end else begin
         n_warps++;
         pending_pixels = {pending_pixels, blend_pixel(px, py)};
      end
      gap = quiet_streams ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_pixel(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      send_word(pwb_pkg::OP_LOAD, px, py, rand_chan(), rand_chan(), rand_chan());
   endtask

   // warp, loading any neighbor it would read that holds nothing yet
   task automatic warp_pixel(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      int lx, ly, u, v;
      if (map_point(px, py, lx, ly, u, v))
         for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
               if (!frame_loaded[(ly + dy) * FRAME_W + lx + dx])
                  load_pixel(POS_W'(lx + dx), POS_W'(ly + dy));
      send_word(pwb_pkg::OP_WARP, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // waits for the block to drain, then writes all coefficients
   task automatic write_coefs(input longint vals [NUM_COEF]);
      req_tvalid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (40) @(posedge clock);
      for (int i = 0; i < NUM_COEF; i++) begin
         csr_we <= 1'b1;
         csr_index <= pwb_pkg::csr_idx_type'(i);
         csr_wdata <= vals[i][COEF_W-1:0];
         @(posedge clock);
         coef[i] = vals[i];
      end
      csr_we <= 1'b0;
   endtask

   function automatic longint rand_span(input longint lo, input longint hi);
      longint span;
      span = hi - lo + 1;
      return lo + longint'({$urandom, $urandom} % span);
   endfunction

   // random perspective that keeps much of the output inside the frame
   task automatic random_coefs();
      longint vals [NUM_COEF];
      vals[0] = rand_span(ONE_Q / 4, 2 * ONE_Q);
      vals[1] = rand_span(-ONE_Q / 5, ONE_Q / 5);
      vals[2] = rand_span(-100 * ONE_Q, 100 * ONE_Q);
      vals[3] = rand_span(-ONE_Q / 5, ONE_Q / 5);
      vals[4] = rand_span(ONE_Q / 4, 2 * ONE_Q);
      vals[5] = rand_span(-100 * ONE_Q, 100 * ONE_Q);
      vals[6] = rand_span(-ONE_Q / 1500, ONE_Q / 1500);
      vals[7] = rand_span(-ONE_Q / 1500, ONE_Q / 1500);
      write_coefs(vals);
   endtask

   task automatic random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         warp_pixel(POS_W'($urandom_range(0, 600)), POS_W'($urandom_range(0, 600)));
      else if (pick < 72)
         warp_pixel(POS_W'($urandom), POS_W'($urandom));
      else if (pick < 93)
         load_pixel(POS_W'($urandom_range(0, FRAME_W - 1)),
                    POS_W'($urandom_range(0, FRAME_H - 1)));
      else
         load_pixel(POS_W'($urandom), POS_W'($urandom));
   endtask

   // corners, edges, blends and the outside cases
   task automatic test_directed();
      longint vals [NUM_COEF];
      send_word(pwb_pkg::OP_LOAD, 0, 0, 8'h00, 8'h00, 8'h00);
      send_word(pwb_pkg::OP_LOAD, 1, 0, 8'hff, 8'hff, 8'hff);
      send_word(pwb_pkg::OP_LOAD, 0, 1, 8'hff, 8'h00, 8'hff);
      send_word(pwb_pkg::OP_LOAD, 1, 1, 8'h00, 8'hff, 8'h00);
      send_word(pwb_pkg::OP_LOAD, 4095, 4095, 8'hff, 8'hff, 8'hff);
      warp_pixel(0, 0);
      warp_pixel(FRAME_W - 2, FRAME_H - 2);
      warp_pixel(FRAME_W - 1, 0);
      warp_pixel(0, FRAME_H - 1);
      warp_pixel(4095, 4095);
      // half scale gives half fractions
      vals = '{ONE_Q / 2, 0, 0, 0, ONE_Q / 2, 0, 0, 0};
      write_coefs(vals);
      warp_pixel(1, 1);
      warp_pixel(3, 0);
      warp_pixel(1019, 1019);
      // negative numerator
      vals = '{ONE_Q, 0, -ONE_Q, 0, ONE_Q, 0, 0, 0};
      write_coefs(vals);
      warp_pixel(0, 5);
      warp_pixel(1, 5);
      // denominator falls to zero and below
      vals = '{ONE_Q, 0, 0, 0, ONE_Q, 0, -ONE_Q / 8, 0};
      write_coefs(vals);
      warp_pixel(4, 4);
      warp_pixel(8, 3);
      warp_pixel(100, 3);
      // coefficient extremes
      vals = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN};
      write_coefs(vals);
      warp_pixel(0, 0);
      warp_pixel(4095, 0);
      warp_pixel(0, 4095);
      vals = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
      write_coefs(vals);
      warp_pixel(0, 0);
      warp_pixel(4095, 4095);
   endtask

   // random words over several random perspectives
   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         random_coefs();
         quiet_streams = (phase == 2);
         repeat (120) random_word();
         quiet_streams = 0;
      end
   endtask

   // consumer holds off while words keep coming
   task automatic test_backpressure();
      longint vals [NUM_COEF];
      vals = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0};
      write_coefs(vals);
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++)
            load_pixel(POS_W'(i), POS_W'(j));
      quiet_streams = 1;
      hold_cycles = 300;
      for (int i = 0; i < 100; i++)
         warp_pixel(POS_W'($urandom_range(0, 6)), POS_W'($urandom_range(0, 2)));
      quiet_streams = 0;
      // sender pauses until every result is back
      req_tvalid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (100) random_word();
   endtask

   // result consumer and checker
   initial begin
      warp_pixel_type exp_pix;
      int stall;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = quiet_streams ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, actual rgb %h inside %b",
                     $realtime, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_pix = pending_pixels.pop_front();
            n_checked++;
            if (exp_pix.in_frame) n_inside++;
            if (rsp_tdata[7:0] !== exp_pix.red) begin
               $display("%0t: red expected %h actual %h", $realtime, exp_pix.red,
                        rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== exp_pix.green) begin
               $display("%0t: green expected %h actual %h", $realtime, exp_pix.green,
                        rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[23:16] !== exp_pix.blue) begin
               $display("%0t: blue expected %h actual %h", $realtime, exp_pix.blue,
                        rsp_tdata[23:16]);
               errors++;
            end
            if (rsp_tuser !== exp_pix.in_frame) begin
               $display("%0t: inside expected %b actual %b", $realtime, exp_pix.in_frame,
                        rsp_tuser);
               errors++;
            end
         end
      end
   end

   // main sequence
   initial begin
      for (int i = 0; i < NUM_COEF; i++) coef[i] = pwb_pkg::COEF_RESET[i];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      req_tvalid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d warps, %0d results checked, %0d inside",
               n_loads, n_warps, n_checked, n_inside);
      $display("mappings: identity, half scale, negative offset, vanishing denominator,");
      $display("          extreme coefficients, random perspectives, long output stall");
      if (errors == 0) begin
         $display("tb_perspective_warp_bilinear: done, clean");
      end else begin
         $display("tb_perspective_warp_bilinear: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("tb_perspective_warp_bilinear: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/pwb_pkg.sv
design/pwb_ram.sv
design/pwb_fifo.sv
design/pwb_front.sv
design/pwb_div.sv
design/pwb_back.sv
design/perspective_warp_bilinear.sv
tb/tb_perspective_warp_bilinear.sv
